// File: hdl/hff_pkg.sv
// ----------------------------------------------------------------------------
// hff_pkg: shared types and helpers for the hex field formatter
// Field limits, the descriptor that the front passes to the back, and the
// conversion of a nibble into an ASCII hex digit.
// ----------------------------------------------------------------------------
package hff_pkg;

    localparam int MAX_FIELD  = 64;
    localparam int FW         = 7;                      // width of a field count
    localparam int VW         = 32;                     // width of the value
    localparam int NIBBLES    = VW / 4;
    localparam int NDW        = $clog2(NIBBLES + 1);    // width of a digit count
    localparam int Q_DEPTH    = 4;
    localparam int QAW        = $clog2(Q_DEPTH);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;          // '0'
    localparam logic [7:0] CHAR_SPACE = 8'h20;          // ' '
    localparam logic [7:0] CHAR_UA    = 8'h41;          // 'A'
    localparam logic [7:0] CHAR_LA    = 8'h61;          // 'a'

    // One classified request: the value left-aligned so that its most
    // significant digit sits in the top nibble, and the segment bounds.
    typedef struct packed {
        logic [VW-1:0] value;
        logic [FW-1:0] bound1;   // end of the first segment
        logic [FW-1:0] bound2;   // end of the second segment
        logic [FW-1:0] total;    // characters in the field, never zero once queued
        logic          pad_zero;
        logic          left;
        logic          upper;
    } t_desc;

    // Read side of the descriptor queue.
    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_head;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UA : CHAR_LA;
        if (nib < 4'd10) begin
            hex_ascii = CHAR_ZERO + {4'd0, nib};
        end else begin
            hex_ascii = base + {4'd0, nib} - 8'd10;
        end
    endfunction

endpackage

// File: hdl/hff_front.sv
// ----------------------------------------------------------------------------
// hff_front: request classification
// Saturates the spec, counts the hex digits and works out the lengths of
// the pad, leading-zero and digit segments of the field.
// ----------------------------------------------------------------------------
module hff_front import hff_pkg::*; (
    input  logic [VW-1:0] i_value,
    input  logic [FW-1:0] i_field_width,
    input  logic [FW-1:0] i_precision,
    input  logic          i_has_dot,
    input  logic          i_zero_flag,
    input  logic          i_left_justify,
    input  logic          i_upper_case,
    output t_desc         o_desc,
    output logic          o_nonempty
);

    logic [FW-1:0]  width_sat;
    logic [FW-1:0]  prec_sat;
    logic [NDW-1:0] ndig;
    logic [NDW-1:0] top_nib;
    logic [FW-1:0]  ndig_w;
    logic [FW-1:0]  lead;
    logic [FW-1:0]  body;
    logic [FW-1:0]  pad;
    logic [5:0]     align;

    assign width_sat = (i_field_width > FW'(MAX_FIELD)) ? FW'(MAX_FIELD) : i_field_width;
    assign prec_sat  = (i_precision   > FW'(MAX_FIELD)) ? FW'(MAX_FIELD) : i_precision;

    // Position of the most significant non-zero nibble; a zero value still
    // has one digit.
    always_comb begin
        top_nib = NDW'(1);
        for (int k = 0; k < NIBBLES; k++) begin
            if (i_value[4*k +: 4] != 4'd0) begin
                top_nib = NDW'(k + 1);
            end
        end
    end

    assign ndig   = (i_value == '0 && i_has_dot && prec_sat == '0) ? '0 : top_nib;
    assign ndig_w = FW'(ndig);
    assign lead   = (prec_sat > ndig_w) ? prec_sat - ndig_w : '0;
    assign body   = lead + ndig_w;
    assign pad    = (width_sat > body) ? width_sat - body : '0;
    assign align  = {(NDW'(NIBBLES) - ndig), 2'b00};

    always_comb begin
        o_desc.value    = i_value << align;
        o_desc.total    = body + pad;
        o_desc.pad_zero = i_zero_flag && !i_has_dot && !i_left_justify;
        o_desc.left     = i_left_justify;
        o_desc.upper    = i_upper_case;
        if (i_left_justify) begin
            o_desc.bound1 = lead;
            o_desc.bound2 = body;
        end else begin
            o_desc.bound1 = pad;
            o_desc.bound2 = pad + lead;
        end
    end

    assign o_nonempty = (body + pad) != '0;

endmodule

// File: hdl/hff_queue.sv
// ----------------------------------------------------------------------------
// hff_queue: descriptor queue between front and back
// A small first-word-fall-through queue held in flip-flops.
// ----------------------------------------------------------------------------
module hff_queue import hff_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_desc   i_desc,
    input  logic    i_rd,
    output logic    o_full,
    output t_q_head o_head
);

    t_desc          r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wptr, n_wptr;
    logic [QAW-1:0] r_rptr, n_rptr;
    logic [QAW:0]   r_count, n_count;
    logic           do_wr;
    logic           do_rd;

    assign o_full = (r_count == (QAW+1)'(Q_DEPTH));
    assign do_wr  = i_wr && !o_full;
    assign do_rd  = i_rd && (r_count != '0);
    // The head is the valid flag followed by the oldest descriptor.
    assign o_head = {(r_count != '0), r_mem[r_rptr]};

    always_comb begin
        n_wptr  = do_wr ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_rd ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(Q_DEPTH))
        else $error("descriptor queue count beyond depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == (QAW+1)'(Q_DEPTH)) |-> r_wptr == r_rptr)
        else $error("queue pointers disagree with count");
    a_rd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd && !o_head.valid) |=> r_count == $past(r_count) + (QAW+1)'($past(do_wr)))
        else $error("read from an empty queue changed the count");
`endif

endmodule

// File: hdl/hff_back.sv
// ----------------------------------------------------------------------------
// hff_back: character sequencer
// Walks one descriptor a character at a time into a single output register.
// ----------------------------------------------------------------------------
module hff_back import hff_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_q_head       i_head,
    output logic          o_q_rd,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_char,
    output logic          o_last,
    output logic [FW-1:0] o_char_count
);

    t_desc         r_desc, n_desc;
    logic [VW-1:0] r_val, n_val;
    logic [FW-1:0] r_pos, n_pos;
    logic          r_busy, n_busy;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_char, n_char;
    logic          r_last, n_last;
    logic [FW-1:0] r_count, n_count;

    logic          out_free;
    logic          emit;
    logic          is_last;
    logic          in_first;
    logic          in_second;
    logic          is_digit;
    logic [7:0]    pad_char;
    logic [7:0]    cur_char;
    logic          load;

    assign out_free  = !r_out_valid || i_pop;
    assign emit      = r_busy && out_free;
    assign is_last   = (r_pos + 1'b1) == r_desc.total;
    assign in_first  = r_pos < r_desc.bound1;
    assign in_second = r_pos < r_desc.bound2;
    assign pad_char  = r_desc.pad_zero ? CHAR_ZERO : CHAR_SPACE;
    assign load      = i_head.valid && (!r_busy || (emit && is_last));
    assign o_q_rd    = load;

    // Segment order is pad, zeros, digits; or zeros, digits, pad when left
    // justified.
    always_comb begin
        is_digit = 1'b0;
        if (r_desc.left) begin
            if (in_first) begin
                cur_char = CHAR_ZERO;
            end else if (in_second) begin
                cur_char = hex_ascii(r_val[VW-1 -: 4], r_desc.upper);
                is_digit = 1'b1;
            end else begin
                cur_char = pad_char;
            end
        end else begin
            if (in_first) begin
                cur_char = pad_char;
            end else if (in_second) begin
                cur_char = CHAR_ZERO;
            end else begin
                cur_char = hex_ascii(r_val[VW-1 -: 4], r_desc.upper);
                is_digit = 1'b1;
            end
        end
    end

    always_comb begin
        n_desc      = r_desc;
        n_val       = r_val;
        n_pos       = r_pos;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        n_count     = r_count;
        if (load) begin
            n_desc = i_head.desc;
            n_val  = i_head.desc.value;
            n_pos  = '0;
            n_busy = 1'b1;
        end else if (emit && is_last) begin
            n_busy = 1'b0;
        end else if (emit) begin
            n_pos = r_pos + 1'b1;
            if (is_digit) begin
                n_val = r_val << 4;
            end
        end
        if (emit) begin
            n_out_valid = 1'b1;
            n_char      = cur_char;
            n_last      = is_last;
            n_count     = is_last ? r_desc.total : '0;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_desc  <= n_desc;
        r_val   <= n_val;
        r_pos   <= n_pos;
        r_char  <= n_char;
        r_last  <= n_last;
        r_count <= n_count;
    end

    assign o_empty      = !r_out_valid;
    assign o_out_char   = r_char;
    assign o_last       = r_last;
    assign o_char_count = r_count;

`ifndef SYNTH
    a_pos_in_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pos < r_desc.total)
        else $error("character position beyond field length");
    a_count_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> r_count != '0)
        else $error("final character without a count");
    a_count_elsewhere: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> r_count == '0)
        else $error("count on a character that is not the final one");
`endif

endmodule

// File: hdl/hex_field_formatter_core.sv
// ----------------------------------------------------------------------------
// hex_field_formatter_core: printf-style hex field formatter
// Turns a value and a conversion spec into a stream of ASCII characters.
// ----------------------------------------------------------------------------
// Each request carries a 32-bit value and a spec (width, precision, dot, zero
// flag, left justify, upper case); the block returns the field one character
// per result, the final one marked by o_last with the field length on
// o_char_count. Characters leave at one per clock cycle while pop is held
// high; a field holds 1 to 64 characters. This rate is set by the character
// sequencer, which produces one character per cycle into a single output
// register whenever that register is empty or popped. Consecutive requests
// follow each other without a gap, as the next descriptor is loaded on the
// cycle that issues the previous final character; from an idle block the
// first character appears after the queue and the sequencer's descriptor and
// output registers. A request whose field is empty is accepted and produces
// no result. Up to four classified requests wait in a queue between the
// classifier and the sequencer, so full rises only when that queue is full.
// There is no configuration and no state across requests beyond the queue.
module hex_field_formatter_core import hff_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [VW-1:0] i_value,
    input  logic [FW-1:0] i_field_width,
    input  logic [FW-1:0] i_precision,
    input  logic          i_has_dot,
    input  logic          i_zero_flag,
    input  logic          i_left_justify,
    input  logic          i_upper_case,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    o_out_char,
    output logic          o_last,
    output logic [FW-1:0] o_char_count
);

    t_desc   front_desc;
    logic    front_nonempty;
    logic    q_full;
    t_q_head q_head;
    logic    q_rd;

    // The classifier is combinational: a request is written to the queue in
    // the cycle it is accepted, unless its field turns out to be empty.
    hff_front u_front (
        .i_value        (i_value),
        .i_field_width  (i_field_width),
        .i_precision    (i_precision),
        .i_has_dot      (i_has_dot),
        .i_zero_flag    (i_zero_flag),
        .i_left_justify (i_left_justify),
        .i_upper_case   (i_upper_case),
        .o_desc         (front_desc),
        .o_nonempty     (front_nonempty)
    );

    hff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push && front_nonempty),
        .i_desc  (front_desc),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    // The sequencer drains the queue and drives the result ports directly
    // from its output register.
    hff_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_char   (o_out_char),
        .o_last       (o_last),
        .o_char_count (o_char_count)
    );

    assign full = q_full;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the hex field formatter
// Drives conversion requests through the push/full side, predicts every
// character of each formatted field and checks the pop/empty side against it.
// ----------------------------------------------------------------------------
module tb_top;
    import hff_pkg::*;

    // The receiver holds off for this many cycles in the back-pressure test.
    localparam int HOLD_CYCLES  = 400;
    // Cycles to wait for outstanding characters before giving up.
    localparam int DRAIN_GUARD  = 20000;
    // Cycles allowed after the last expected character for stray output.
    localparam int SETTLE_CYCLES = 70;
    // Idle probability, in percent, for both sides outside calm stretches.
    localparam int IDLE_PCT     = 28;
    // Random requests across the whole run.
    localparam int N_RANDOM     = 126;

    // One character of a formatted field as it is expected on the outputs.
    typedef struct {
        logic [7:0]    ch;
        logic          last;
        logic [FW-1:0] count;
    } t_field_char;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          push = 1'b0;
    logic          full;
    logic [VW-1:0] i_value = '0;
    logic [FW-1:0] i_field_width = '0;
    logic [FW-1:0] i_precision = '0;
    logic          i_has_dot = 1'b0;
    logic          i_zero_flag = 1'b0;
    logic          i_left_justify = 1'b0;
    logic          i_upper_case = 1'b0;
    logic          empty;
    logic          pop = 1'b0;
    logic [7:0]    o_out_char;
    logic          o_last;
    logic [FW-1:0] o_char_count;

    // Characters still owed by the block, oldest first.
    t_field_char   pending_chars[$];
    int            fail_count = 0;

    // While calm is set neither side idles at random.
    bit            calm = 1'b0;
    // Bumping hold_epoch asks the receiver to hold off for HOLD_CYCLES.
    int            hold_epoch = 0;
    int            hold_seen = 0;
    int            hold_left = 0;

    hex_field_formatter_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_value        (i_value),
        .i_field_width  (i_field_width),
        .i_precision    (i_precision),
        .i_has_dot      (i_has_dot),
        .i_zero_flag    (i_zero_flag),
        .i_left_justify (i_left_justify),
        .i_upper_case   (i_upper_case),
        .empty          (empty),
        .pop            (pop),
        .o_out_char     (o_out_char),
        .o_last         (o_last),
        .o_char_count   (o_char_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // A run that hangs is a failure in its own right.
    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Works out the characters of one formatted field and appends them to
    // the list of pending characters. The field is built in three parts:
    // padding, leading zeros raising the digit count to the precision, then
    // the significant hex digits; with left justify the padding moves to
    // the end.
    function automatic void format_hex_field(input logic [VW-1:0] v,
                                             input logic [FW-1:0] w_in,
                                             input logic [FW-1:0] p_in,
                                             input logic dot, input logic zero,
                                             input logic left, input logic upper);
        string         lc_digits = "0123456789abcdef";
        string         uc_digits = "0123456789ABCDEF";
        logic [7:0]    digs[NIBBLES];
        logic [7:0]    text[$];
        logic [VW-1:0] rest;
        logic [7:0]    pad_ch;
        int            w, p, ndig, lead, body, pad, total;
        t_field_char   fc;

        // Oversized specs are clipped to the largest field.
        w = (w_in > MAX_FIELD) ? MAX_FIELD : int'(w_in);
        p = (p_in > MAX_FIELD) ? MAX_FIELD : int'(p_in);
        ndig = 0;
        // A zero value with an explicit precision of zero has no digits.
        if (!(v == '0 && dot && p == 0)) begin
            rest = v;
            do begin
                digs[ndig] = upper ? uc_digits[rest[3:0]] : lc_digits[rest[3:0]];
                ndig++;
                rest = rest >> 4;
            end while (rest != '0 && ndig < NIBBLES);
        end
        lead = (p > ndig) ? p - ndig : 0;
        body = lead + ndig;
        pad = (w > body) ? w - body : 0;
        total = body + pad;
        if (total > MAX_FIELD) total = MAX_FIELD;
        // Zero padding is only honoured without a precision and right-aligned.
        pad_ch = (zero && !dot && !left) ? CHAR_ZERO : CHAR_SPACE;

        if (!left) repeat (pad) text.push_back(pad_ch);
        repeat (lead) text.push_back(CHAR_ZERO);
        for (int i = ndig - 1; i >= 0; i--) text.push_back(digs[i]);
        if (left) repeat (pad) text.push_back(pad_ch);
        while (text.size() > MAX_FIELD) void'(text.pop_back());

        foreach (text[k]) begin
            fc.ch = text[k];
            fc.last = (k == text.size() - 1);
            fc.count = fc.last ? FW'(total) : '0;
            pending_chars.push_back(fc);
        end
    endfunction

    // Offers one request and returns once it has been accepted; push is
    // left high so that back-to-back requests need no gap.
    task automatic send_request(input logic [VW-1:0] v, input logic [FW-1:0] w,
                                input logic [FW-1:0] p, input logic dot,
                                input logic zero, input logic left,
                                input logic upper);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push           <= 1'b1;
        i_value        <= v;
        i_field_width  <= w;
        i_precision    <= p;
        i_has_dot      <= dot;
        i_zero_flag    <= zero;
        i_left_justify <= left;
        i_upper_case   <= upper;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        format_hex_field(v, w, p, dot, zero, left, upper);
    endtask

    // Stops offering requests and waits for every owed character.
    task automatic wait_all_delivered();
        int guard;
        guard = 0;
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // Draws one request. Most requests use small widths and precisions so
    // the run stays short; a few go up to and past the field limit.
    task automatic send_random_request();
        logic [VW-1:0] v;
        logic [FW-1:0] w, p;
        int            sel;
        sel = $urandom_range(0, 99);
        if (sel < 10) v = '0;
        else if (sel < 25) v = $urandom;
        else v = $urandom >> $urandom_range(0, 31);
        sel = $urandom_range(0, 99);
        if (sel < 75) w = FW'($urandom_range(0, 16));
        else if (sel < 90) w = FW'($urandom_range(17, 64));
        else w = FW'($urandom_range(65, 127));
        sel = $urandom_range(0, 99);
        if (sel < 75) p = FW'($urandom_range(0, 10));
        else if (sel < 90) p = FW'($urandom_range(11, 64));
        else p = FW'($urandom_range(65, 127));
        send_request(v, w, p, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Extremes of every field and each of the special cases by hand.
    task automatic test_directed_cases();
        send_request(32'h0,        7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b0);
        // Zero value with a zero precision: nothing at all is emitted.
        send_request(32'h0,        7'd0,   7'd0,   1'b1, 1'b0, 1'b0, 1'b0);
        // Empty digits but a width: the field is all padding.
        send_request(32'h0,        7'd5,   7'd0,   1'b1, 1'b1, 1'b0, 1'b0);
        send_request(32'h0,        7'd64,  7'd0,   1'b1, 1'b0, 1'b1, 1'b1);
        send_request(32'hFFFFFFFF, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b0);
        send_request(32'hFFFFFFFF, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b1);
        send_request(32'hDEADBEEF, 7'd12,  7'd0,   1'b0, 1'b1, 1'b0, 1'b1);
        send_request(32'h80000000, 7'd9,   7'd8,   1'b1, 1'b0, 1'b0, 1'b0);
        // The zero flag loses to a precision and to left justification.
        send_request(32'h0000ABCD, 7'd10,  7'd4,   1'b1, 1'b1, 1'b0, 1'b0);
        send_request(32'h0000ABCD, 7'd10,  7'd0,   1'b0, 1'b1, 1'b1, 1'b0);
        send_request(32'h000000AB, 7'd8,   7'd4,   1'b1, 1'b0, 1'b1, 1'b1);
        send_request(32'h00000001, 7'd0,   7'd0,   1'b1, 1'b0, 1'b0, 1'b0);
        send_request(32'h00000001, 7'd1,   7'd1,   1'b1, 1'b1, 1'b0, 1'b0);
        send_request(32'h12345678, 7'd64,  7'd0,   1'b0, 1'b1, 1'b0, 1'b0);
        // Oversized width and precision are clipped to the field limit.
        send_request(32'h12345678, 7'd127, 7'd0,   1'b0, 1'b0, 1'b0, 1'b0);
        send_request(32'h0000CAFE, 7'd0,   7'd64,  1'b1, 1'b0, 1'b0, 1'b1);
        send_request(32'h0000CAFE, 7'd0,   7'd127, 1'b1, 1'b0, 1'b1, 1'b0);
        send_request(32'h7FFFFFFF, 7'd127, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1);
        send_request(32'h0000000F, 7'd65,  7'd3,   1'b1, 1'b0, 1'b1, 1'b1);
        send_request(32'h00000000, 7'd3,   7'd5,   1'b1, 1'b0, 1'b0, 1'b0);
        send_request(32'hA5A5A5A5, 7'd0,   7'd65,  1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // A burst of random requests, optionally with neither side idling.
    task automatic test_random_requests(input int n, input bit no_idle);
        calm = no_idle;
        repeat (n) send_random_request();
        calm = 1'b0;
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering short fields, so the descriptor queue fills and full rises.
    task automatic test_output_hold();
        calm = 1'b1;
        hold_epoch++;
        repeat (12) begin
            send_request($urandom >> $urandom_range(8, 31), FW'($urandom_range(0, 6)),
                         FW'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        end
        calm = 1'b0;
    endtask

    // The sender pauses until every owed character is out, then resumes
    // from an idle block.
    task automatic test_drain_pause();
        wait_all_delivered();
        repeat (6) send_random_request();
    endtask

    // Receiver: random pops, a hold-off counted here when one is asked for,
    // and pop held high in calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_epoch != hold_seen) begin
            hold_seen <= hold_epoch;
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else begin
            pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Checker: every popped character is compared with the oldest one owed.
    always @(posedge i_clk) begin
        t_field_char exp_c;
        if (i_rst_n && pop && !empty) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h last %b count %0d",
                                          o_out_char, o_last, o_char_count));
            end else begin
                exp_c = pending_chars.pop_front();
                if (o_out_char !== exp_c.ch)
                    report_mismatch($sformatf("char %h, expected %h",
                                              o_out_char, exp_c.ch));
                if (o_last !== exp_c.last)
                    report_mismatch($sformatf("last %b, expected %b on char %h",
                                              o_last, exp_c.last, exp_c.ch));
                if (o_char_count !== exp_c.count)
                    report_mismatch($sformatf("count %0d, expected %0d on char %h",
                                              o_char_count, exp_c.count, exp_c.ch));
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_requests(50, 1'b0);
        test_output_hold();
        test_random_requests(30, 1'b1);
        test_drain_pause();
        test_random_requests(N_RANDOM - 86, 1'b0);

        // Wait for the tail of the stream, then allow a little longer for
        // any character the block should not have produced.
        wait_all_delivered();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived",
                                      pending_chars.size()));

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
